@@ sv/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants of the timestamp LRU keyed cache
// Command codes, result kinds, request/response item layouts, table entry.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_PROBE  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_RESIZE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               kind;
    logic               hit;
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } rsp_item_t;

  // scan summary; entry indices travel beside it at the table's index width
  typedef struct packed {
    logic               match;
    logic [PAY_W-1:0]   match_payload;
    logic               old_found;
    logic [KEY_W-1:0]   old_key;
    logic [PAY_W-1:0]   old_payload;
    logic               free_found;
  } scan_res_t;

endpackage

@@ sv/tlc_req_if.sv @@
// ----------------------------------------------------------------------------
// tlc_req_if: command request channel
// Valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
interface tlc_req_if;
  logic                          valid;
  logic                          ready;
  logic [tlc_pkg::CMD_W-1:0]     cmd;
  logic [tlc_pkg::KEY_W-1:0]     key;
  logic [tlc_pkg::PAY_W-1:0]     payload;
  logic [tlc_pkg::STAMP_W-1:0]   stamp_now;
  logic [tlc_pkg::CAP_W-1:0]     new_capacity;

  modport source (output valid, cmd, key, payload, stamp_now, new_capacity, input ready);
  modport sink   (input valid, cmd, key, payload, stamp_now, new_capacity, output ready);
endinterface

@@ sv/tlc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tlc_rsp_if: result channel
// Valid/ready handshake with eviction reports and command completions.
// ----------------------------------------------------------------------------
interface tlc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic                        hit;
  logic [tlc_pkg::KEY_W-1:0]   out_key;
  logic [tlc_pkg::PAY_W-1:0]   out_payload;
  logic [tlc_pkg::OCC_W-1:0]   occupancy;
  logic                        last;

  modport source (output valid, kind, hit, out_key, out_payload, occupancy, last,
                  input ready);
  modport sink   (input valid, kind, hit, out_key, out_payload, occupancy, last,
                  output ready);
endinterface

@@ sv/tlc_mem.sv @@
// ----------------------------------------------------------------------------
// tlc_mem: entry storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tlc_mem #(
  parameter int unsigned ENTRIES = tlc_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  tlc_pkg::entry_t       wdata_i,
  input  logic                  re_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output tlc_pkg::entry_t       rdata_o
);

  tlc_pkg::entry_t mem_q [ENTRIES];
  tlc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tlc_scan.sv @@
// ----------------------------------------------------------------------------
// tlc_scan: per-entry scan accumulator
// Takes one entry a cycle; tracks key match, oldest entry and first free slot.
// ----------------------------------------------------------------------------
module tlc_scan #(
  parameter int unsigned ENTRIES = tlc_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          vld_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic                          ent_valid_i,
  input  tlc_pkg::entry_t               ent_i,
  input  logic [tlc_pkg::KEY_W-1:0]     key_i,
  output tlc_pkg::scan_res_t            res_o,
  output logic [IDX_W-1:0]              match_idx_o,
  output logic [IDX_W-1:0]              old_idx_o,
  output logic [IDX_W-1:0]              free_idx_o
);

  logic                          match_q, old_found_q, free_found_q;
  logic [IDX_W-1:0]              match_idx_q, old_idx_q, free_idx_q;
  logic [tlc_pkg::PAY_W-1:0]     match_pay_q, old_pay_q;
  logic [tlc_pkg::KEY_W-1:0]     old_key_q;
  logic [tlc_pkg::STAMP_W-1:0]   old_stamp_q;

  logic is_match, is_older, is_free;

  always_comb begin
    is_match = vld_i && ent_valid_i && !match_q && (ent_i.key == key_i);
    // smaller stamp wins, ties go to the smaller key
    is_older = vld_i && ent_valid_i &&
               (!old_found_q || (ent_i.stamp < old_stamp_q) ||
                ((ent_i.stamp == old_stamp_q) && (ent_i.key < old_key_q)));
    is_free  = vld_i && !ent_valid_i && !free_found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q      <= 1'b0;
      old_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (clr_i) begin
      match_q      <= 1'b0;
      old_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (is_match) match_q      <= 1'b1;
      if (is_older) old_found_q  <= 1'b1;
      if (is_free)  free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_match) begin
      match_idx_q <= idx_i;
      match_pay_q <= ent_i.payload;
    end
    if (is_older) begin
      old_idx_q   <= idx_i;
      old_key_q   <= ent_i.key;
      old_pay_q   <= ent_i.payload;
      old_stamp_q <= ent_i.stamp;
    end
    if (is_free) begin
      free_idx_q  <= idx_i;
    end
  end

  always_comb begin
    res_o.match         = match_q;
    res_o.match_payload = match_pay_q;
    res_o.old_found     = old_found_q;
    res_o.old_key       = old_key_q;
    res_o.old_payload   = old_pay_q;
    res_o.free_found    = free_found_q;
  end

  assign match_idx_o = match_idx_q;
  assign old_idx_o   = old_idx_q;
  assign free_idx_o  = free_idx_q;

endmodule

@@ sv/timestamp_lru_keyed_cache_unit.sv @@
// ----------------------------------------------------------------------------
// timestamp_lru_keyed_cache_unit: fully associative keyed cache, LRU by stamp
// Insert, lookup, probe, remove, resize and clear over a table of ENTRIES.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command request (cmd, key, payload, stamp_now,
//   new_capacity); it is taken when valid and ready are both high. ready is
//   high only while no command is in progress.
//   rsp_o returns zero or more eviction reports (kind 1) followed by one
//   completion (kind 0, last 1) per request.
//   Every command reads the whole table through the single memory read port,
//   one entry a cycle, before it writes its completion result. Each eviction
//   of resize or clear costs one more pass over the table; an insert that
//   evicts adds a fill step after its eviction report.
//   Results go through one output register; if the receiver holds ready low,
//   the sequencer waits before writing the next result and nothing is lost.
//   Reset empties the table (valid bits in flops, no clearing pass) and sets
//   the capacity limit to ENTRIES. Entry contents are not reset.
// ----------------------------------------------------------------------------
module timestamp_lru_keyed_cache_unit #(
  parameter int unsigned ENTRIES = tlc_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlc_req_if.sink     req_i,
  tlc_rsp_if.source   rsp_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_FILL   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  tlc_pkg::cmd_e                 cmd_q;
  logic [tlc_pkg::KEY_W-1:0]     key_q;
  logic [tlc_pkg::PAY_W-1:0]     pay_q;
  logic [tlc_pkg::STAMP_W-1:0]   now_q;
  logic [tlc_pkg::CAP_W-1:0]     ncap_q;

  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [CNT_W-1:0]   cap_q, cap_d;
  logic               out_valid_q, out_valid_d;
  tlc_pkg::rsp_item_t out_q, out_d;

  logic               latch;
  logic               scan_clr;
  logic               rd_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  tlc_pkg::entry_t    mem_wdata;
  tlc_pkg::entry_t    mem_rdata;

  tlc_pkg::scan_res_t sr;
  logic [IDX_W-1:0]   match_idx, old_idx, free_idx, fill_idx;
  logic               out_free;
  logic [CNT_W-1:0]   ncap_sat;
  logic [CNT_W-1:0]   occ_dec;

  tlc_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  tlc_scan #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (scan_clr),
    .vld_i       (rd_pend_q),
    .idx_i       (rd_idx_q),
    .ent_valid_i (valid_q[rd_idx_q]),
    .ent_i       (mem_rdata),
    .key_i       (key_q),
    .res_o       (sr),
    .match_idx_o (match_idx),
    .old_idx_o   (old_idx),
    .free_idx_o  (free_idx)
  );

  assign out_free = !out_valid_q || rsp_o.ready;
  assign occ_dec  = occ_q - CNT_W'(1);
  assign ncap_sat = (32'(ncap_q) > 32'(ENTRIES)) ? FULL_CNT : CNT_W'(ncap_q);
  // after an eviction the lowest free slot may be the victim's
  assign fill_idx = (!sr.free_found || (old_idx < free_idx)) ? old_idx : free_idx;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    latch       = 1'b0;
    scan_clr    = 1'b0;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = match_idx;
    mem_wdata   = '{key: key_q, payload: pay_q, stamp: now_q};

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          latch    = 1'b1;
          scan_clr = 1'b1;
          ptr_d    = '0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (ptr_q < FULL_CNT) begin
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
        end
        if (rd_pend_q && (rd_idx_q == LAST_IDX)) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          // completion defaults; arms below override hit, payload and occupancy
          out_d = '{kind: tlc_pkg::KIND_DONE, hit: 1'b0, out_key: key_q,
                    out_payload: '0, occupancy: tlc_pkg::OCC_W'(occ_q), last: 1'b1};
          state_d = ST_IDLE;
          unique case (cmd_q)
            tlc_pkg::CMD_INSERT: begin
              if (sr.match) begin
                mem_we    = 1'b1;
                out_d.hit = 1'b1;
              end else if ((occ_q >= cap_q) && (occ_q != '0)) begin
                valid_d[old_idx] = 1'b0;
                occ_d   = occ_dec;
                out_d   = '{kind: tlc_pkg::KIND_EVICT, hit: 1'b0, out_key: sr.old_key,
                            out_payload: sr.old_payload,
                            occupancy: tlc_pkg::OCC_W'(occ_dec), last: 1'b0};
                state_d = ST_FILL;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = free_idx;
                valid_d[free_idx] = 1'b1;
                occ_d             = occ_q + CNT_W'(1);
                out_d.occupancy   = tlc_pkg::OCC_W'(occ_q + CNT_W'(1));
              end
            end
            tlc_pkg::CMD_LOOKUP: begin
              if (sr.match) begin
                mem_we            = 1'b1;
                mem_wdata.payload = sr.match_payload;
                out_d.hit         = 1'b1;
                out_d.out_payload = sr.match_payload;
              end
            end
            tlc_pkg::CMD_PROBE: begin
              out_d.hit = sr.match;
            end
            tlc_pkg::CMD_REMOVE: begin
              if (sr.match) begin
                valid_d[match_idx] = 1'b0;
                occ_d              = occ_dec;
                out_d.hit          = 1'b1;
                out_d.occupancy    = tlc_pkg::OCC_W'(occ_dec);
              end
            end
            tlc_pkg::CMD_RESIZE, tlc_pkg::CMD_CLEAR: begin
              if ((cmd_q == tlc_pkg::CMD_CLEAR) ? (occ_q != '0) : (occ_q > ncap_sat)) begin
                // evict the oldest, then rescan for the next one
                valid_d[old_idx] = 1'b0;
                occ_d    = occ_dec;
                out_d    = '{kind: tlc_pkg::KIND_EVICT, hit: 1'b0, out_key: sr.old_key,
                             out_payload: sr.old_payload,
                             occupancy: tlc_pkg::OCC_W'(occ_dec), last: 1'b0};
                scan_clr = 1'b1;
                ptr_d    = '0;
                state_d  = ST_SCAN;
              end else if (cmd_q == tlc_pkg::CMD_RESIZE) begin
                cap_d = ncap_sat;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FILL: begin
        if (out_free) begin
          mem_we            = 1'b1;
          mem_waddr         = fill_idx;
          valid_d[fill_idx] = 1'b1;
          occ_d             = occ_q + CNT_W'(1);
          out_valid_d       = 1'b1;
          out_d = '{kind: tlc_pkg::KIND_DONE, hit: 1'b0, out_key: key_q, out_payload: '0,
                    occupancy: tlc_pkg::OCC_W'(occ_q + CNT_W'(1)), last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= FULL_CNT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rd_pend_q   <= rd_pend_d;
      rd_idx_q    <= rd_idx_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (latch) begin
      cmd_q  <= tlc_pkg::cmd_e'(req_i.cmd);
      key_q  <= req_i.key;
      pay_q  <= req_i.payload;
      now_q  <= req_i.stamp_now;
      ncap_q <= req_i.new_capacity;
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.kind        = out_q.kind;
  assign rsp_o.hit         = out_q.hit;
  assign rsp_o.out_key     = out_q.out_key;
  assign rsp_o.out_payload = out_q.out_payload;
  assign rsp_o.occupancy   = out_q.occupancy;
  assign rsp_o.last        = out_q.last;

endmodule

@@ sv/tlc_chk.sv @@
// ----------------------------------------------------------------------------
// tlc_chk: port-level checks for the keyed cache
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module tlc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          rsp_kind_i,
  input logic                          rsp_hit_i,
  input logic                          rsp_last_i,
  input logic [tlc_pkg::KEY_W-1:0]     rsp_key_i,
  input logic [tlc_pkg::OCC_W-1:0]     rsp_occ_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_key_i) && $stable(rsp_occ_i))
    else $error("stalled result changed");

  // an eviction report is never the closing result and never a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i == tlc_pkg::KIND_EVICT) |-> !rsp_last_i && !rsp_hit_i)
    else $error("eviction report flagged last or hit");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // an eviction is always followed by more work of the same command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i == tlc_pkg::KIND_EVICT) |-> !req_ready_i)
    else $error("idle with an eviction pending");

endmodule

bind timestamp_lru_keyed_cache_unit tlc_chk u_tlc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_kind_i  (rsp_o.kind),
  .rsp_hit_i   (rsp_o.hit),
  .rsp_last_i  (rsp_o.last),
  .rsp_key_i   (rsp_o.out_key),
  .rsp_occ_i   (rsp_o.occupancy)
);

@@ tb/timestamp_lru_keyed_cache_unit_tb.sv @@
// ----------------------------------------------------------------------------
// timestamp_lru_keyed_cache_unit_tb: self-checking bench for the keyed LRU cache
// A directed table covers the extremes and the corner cases. Random commands
// follow, in four handshake pressure phases. Every result is compared
// field by field with a shadow table prediction or a directed row's value.
// ----------------------------------------------------------------------------
module timestamp_lru_keyed_cache_unit_tb;
  import tlc_pkg::*;

  localparam int unsigned DEPTH        = ENTRIES_DEF;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned RANDOM_ITEMS = 308;
  localparam int unsigned KEY_POOL     = 20;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam int unsigned DRAIN_CYCLES = 60;

  // codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [STAMP_W-1:0] stamp;
    logic [CAP_W-1:0]   ncap;
  } cache_req_t;

  typedef struct {
    cache_req_t         r;
    bit                 typed;
    logic               hit;
    logic [PAY_W-1:0]   pay;
    logic [OCC_W-1:0]   occ;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  tlc_req_if req_if ();
  tlc_rsp_if rsp_if ();

  timestamp_lru_keyed_cache_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow table
  logic               shadow_valid   [DEPTH];
  logic [KEY_W-1:0]   shadow_key     [DEPTH];
  logic [PAY_W-1:0]   shadow_payload [DEPTH];
  logic [STAMP_W-1:0] shadow_stamp   [DEPTH];
  int unsigned        shadow_cap;

  rsp_item_t          pending_rsp [$];
  dir_row_t           dir_rows [$];
  logic [KEY_W-1:0]   key_pool [KEY_POOL];
  logic [STAMP_W-1:0] now_ms;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned err_count      = 0;
  int unsigned rsp_seen       = 0;

  function automatic int unsigned shadow_fill();
    int unsigned n = 0;
    for (int i = 0; i < DEPTH; i++)
      if (shadow_valid[i]) n++;
    return n;
  endfunction

  function automatic int shadow_find(input logic [KEY_W-1:0] k);
    int idx = -1;
    for (int i = 0; i < DEPTH; i++)
      if (idx < 0 && shadow_valid[i] && shadow_key[i] == k) idx = i;
    return idx;
  endfunction

  // smallest stamp, ties to the smallest key
  function automatic int shadow_oldest();
    int best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (shadow_valid[i]) begin
        if (best < 0 || shadow_stamp[i] < shadow_stamp[best] ||
            (shadow_stamp[i] == shadow_stamp[best] && shadow_key[i] < shadow_key[best]))
          best = i;
      end
    end
    return best;
  endfunction

  function automatic void push_rsp(input logic kind, input logic hit,
                                   input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p,
                                   input logic [OCC_W-1:0] occ, input logic last);
    rsp_item_t e;
    e.kind        = kind;
    e.hit         = hit;
    e.out_key     = k;
    e.out_payload = p;
    e.occupancy   = occ;
    e.last        = last;
    pending_rsp.push_back(e);
  endfunction

  function automatic void shadow_evict();
    int v = shadow_oldest();
    if (v < 0) return;
    shadow_valid[v] = 1'b0;
    push_rsp(KIND_EVICT, 1'b0, shadow_key[v], shadow_payload[v],
             OCC_W'(shadow_fill()), 1'b0);
  endfunction

  function automatic void predict_command(input cache_req_t r);
    int               idx   = shadow_find(r.key);
    logic             hit   = 1'b0;
    logic [PAY_W-1:0] found = '0;
    int unsigned      ncap;
    bit               placed;
    case (r.cmd)
      CMD_INSERT: begin
        if (idx >= 0) begin
          hit = 1'b1;
          shadow_payload[idx] = r.payload;
          shadow_stamp[idx]   = r.stamp;
        end else begin
          // a full table gives up its oldest entry; capacity zero still holds one
          if (shadow_fill() >= shadow_cap && shadow_fill() > 0) shadow_evict();
          placed = 1'b0;
          for (int i = 0; i < DEPTH; i++) begin
            if (!placed && !shadow_valid[i]) begin
              shadow_valid[i]   = 1'b1;
              shadow_key[i]     = r.key;
              shadow_payload[i] = r.payload;
              shadow_stamp[i]   = r.stamp;
              placed            = 1'b1;
            end
          end
        end
      end
      CMD_LOOKUP: begin
        if (idx >= 0) begin
          hit = 1'b1;
          shadow_stamp[idx] = r.stamp;
          found = shadow_payload[idx];
        end
      end
      CMD_PROBE: begin
        if (idx >= 0) hit = 1'b1;
      end
      CMD_REMOVE: begin
        if (idx >= 0) begin
          hit = 1'b1;
          shadow_valid[idx] = 1'b0;
        end
      end
      CMD_RESIZE: begin
        ncap = (r.ncap > DEPTH) ? DEPTH : r.ncap;
        while (shadow_fill() > ncap) shadow_evict();
        shadow_cap = ncap;
      end
      CMD_CLEAR: begin
        while (shadow_fill() > 0) shadow_evict();
      end
      default: ;
    endcase
    push_rsp(KIND_DONE, hit, r.key, found, OCC_W'(shadow_fill()), 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch at result %0d: %s got %h want %h", rsp_seen, what, got, want);
  endtask

  task automatic check_rsp(input rsp_item_t got);
    rsp_item_t want;
    rsp_seen++;
    if (pending_rsp.size() == 0) begin
      report_mismatch("unexpected result, key", got.out_key, '0);
      return;
    end
    want = pending_rsp.pop_front();
    if (got.kind !== want.kind)               report_mismatch("kind", got.kind, want.kind);
    if (got.hit !== want.hit)                 report_mismatch("hit", got.hit, want.hit);
    if (got.out_key !== want.out_key)         report_mismatch("out_key", got.out_key, want.out_key);
    if (got.out_payload !== want.out_payload)
      report_mismatch("out_payload", got.out_payload, want.out_payload);
    if (got.occupancy !== want.occupancy)
      report_mismatch("occupancy", got.occupancy, want.occupancy);
    if (got.last !== want.last)               report_mismatch("last", got.last, want.last);
  endtask

  // caller sits at a rising edge; returns at the edge that took the request
  task automatic issue_req(input cache_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= r.cmd;
    req_if.key          <= r.key;
    req_if.payload      <= r.payload;
    req_if.stamp_now    <= r.stamp;
    req_if.new_capacity <= r.ncap;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predict_command(r);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                         input logic [PAY_W-1:0] p, input logic [STAMP_W-1:0] s,
                         input logic [CAP_W-1:0] c, input bit typed, input logic hit,
                         input logic [PAY_W-1:0] epay, input logic [OCC_W-1:0] eocc);
    dir_row_t row;
    row.r.cmd     = cmd;
    row.r.key     = k;
    row.r.payload = p;
    row.r.stamp   = s;
    row.r.ncap    = c;
    row.typed     = typed;
    row.hit       = hit;
    row.pay       = epay;
    row.occ       = eocc;
    dir_rows.push_back(row);
  endtask

  function automatic cache_req_t random_req();
    cache_req_t  r;
    int unsigned pick = $urandom_range(99);
    int unsigned cap_pick = $urandom_range(3);
    r.key     = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL-1)] : $urandom;
    r.payload = ($urandom_range(19) == 0) ? '0 : $urandom;
    now_ms    = now_ms + $urandom_range(3);
    // small steps in time give frequent stamp ties
    r.stamp   = ($urandom_range(9) == 0) ? $urandom : now_ms;
    if (cap_pick == 0)      r.ncap = CAP_W'($urandom_range(31));
    else if (cap_pick == 1) r.ncap = CAP_W'(DEPTH);
    else                    r.ncap = CAP_W'($urandom_range(16, 4));
    if (pick < 38)      r.cmd = CMD_INSERT;
    else if (pick < 58) r.cmd = CMD_LOOKUP;
    else if (pick < 70) r.cmd = CMD_PROBE;
    else if (pick < 82) r.cmd = CMD_REMOVE;
    else if (pick < 92) r.cmd = CMD_RESIZE;
    else if (pick < 95) r.cmd = CMD_CLEAR;
    else if (pick < 98) r.cmd = CMD_SPARE6;
    else                r.cmd = CMD_SPARE7;
    return r;
  endfunction

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    rsp_item_t got;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.kind        = rsp_if.kind;
        got.hit         = rsp_if.hit;
        got.out_key     = rsp_if.out_key;
        got.out_payload = rsp_if.out_payload;
        got.occupancy   = rsp_if.occupancy;
        got.last        = rsp_if.last;
        check_rsp(got);
      end
      if (hold_request) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin
    int unsigned quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    req_if.valid        <= 1'b0;
    req_if.cmd          <= CMD_INSERT;
    req_if.key          <= '0;
    req_if.payload      <= '0;
    req_if.stamp_now    <= '0;
    req_if.new_capacity <= '0;

    for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 1'b0;
    shadow_cap = DEPTH;
    now_ms     = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    //       cmd         key           payload       stamp         cap    typed hit pay  occ
    add_row(CMD_PROBE,  32'h0,        32'h0,        32'h0,        5'd0,  1, 0, 32'h0, 5'd0);
    add_row(CMD_LOOKUP, 32'hFFFFFFFF, 32'h0,        32'h1,        5'd0,  1, 0, 32'h0, 5'd0);
    add_row(CMD_REMOVE, 32'h5,        32'h0,        32'h0,        5'd0,  1, 0, 32'h0, 5'd0);
    add_row(CMD_CLEAR,  32'h0,        32'h0,        32'h0,        5'd0,  1, 0, 32'h0, 5'd0);
    add_row(CMD_INSERT, 32'h0,        32'hFFFFFFFF, 32'h0,        5'd0,  1, 0, 32'h0, 5'd1);
    add_row(CMD_INSERT, 32'hFFFFFFFF, 32'h0,        32'hFFFFFFFF, 5'd31, 1, 0, 32'h0, 5'd2);
    add_row(CMD_LOOKUP, 32'h0,        32'h0,        32'd100,      5'd0,  1, 1, 32'hFFFFFFFF, 5'd2);
    add_row(CMD_PROBE,  32'hFFFFFFFF, 32'h0,        32'h0,        5'd0,  1, 1, 32'h0, 5'd2);
    // overwrite of a present key
    add_row(CMD_INSERT, 32'h0,        32'h1234,     32'd50,       5'd0,  1, 1, 32'h0, 5'd2);
    add_row(CMD_SPARE6, 32'h55,       32'h0,        32'h0,        5'd0,  1, 0, 32'h0, 5'd2);
    add_row(CMD_SPARE7, 32'hAA,       32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31, 1, 0, 32'h0, 5'd2);
    add_row(CMD_RESIZE, 32'h0,        32'h0,        32'h0,        5'd1,  0, 0, 32'h0, 5'd0);
    add_row(CMD_INSERT, 32'h3,        32'h33,       32'd7,        5'd0,  0, 0, 32'h0, 5'd0);
    add_row(CMD_RESIZE, 32'h0,        32'h0,        32'h0,        5'd0,  0, 0, 32'h0, 5'd0);
    // capacity zero still keeps one entry
    add_row(CMD_INSERT, 32'h9,        32'h99,       32'd5,        5'd0,  0, 0, 32'h0, 5'd0);
    add_row(CMD_INSERT, 32'hA,        32'hAA,       32'd5,        5'd0,  0, 0, 32'h0, 5'd0);
    // above the depth saturates, nothing leaves
    add_row(CMD_RESIZE, 32'h0,        32'h0,        32'h0,        5'd31, 1, 0, 32'h0, 5'd1);
    add_row(CMD_INSERT, 32'd22,       32'h22,       32'd2,        5'd0,  0, 0, 32'h0, 5'd0);
    add_row(CMD_INSERT, 32'd21,       32'h21,       32'd2,        5'd0,  0, 0, 32'h0, 5'd0);
    add_row(CMD_INSERT, 32'd20,       32'h20,       32'd2,        5'd0,  0, 0, 32'h0, 5'd0);
    add_row(CMD_LOOKUP, 32'hA,        32'h0,        32'd9,        5'd0,  0, 0, 32'h0, 5'd0);
    // equal stamps: smallest key leaves first
    add_row(CMD_RESIZE, 32'h0,        32'h0,        32'h0,        5'd2,  0, 0, 32'h0, 5'd0);
    add_row(CMD_REMOVE, 32'hA,        32'h0,        32'h0,        5'd0,  0, 0, 32'h0, 5'd0);
    add_row(CMD_INSERT, 32'h0,        32'h0,        32'h0,        5'd16, 0, 0, 32'h0, 5'd0);
    add_row(CMD_CLEAR,  32'h0,        32'h0,        32'h0,        5'd0,  0, 0, 32'h0, 5'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      issue_req(dir_rows[i].r);
      if (dir_rows[i].typed) begin
        // hand-written completion stands in for the predicted one
        void'(pending_rsp.pop_back());
        push_rsp(KIND_DONE, dir_rows[i].hit, dir_rows[i].r.key, dir_rows[i].pay,
                 dir_rows[i].occ, 1'b1);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // receiver sits out a long stretch while requests keep coming
      if (ph == 0) hold_request = 1'b1;
      repeat (RANDOM_ITEMS / 4) issue_req(random_req());
    end
    req_if.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
